FILE: sv/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY     = 256;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 9;
  localparam int FILL_W       = 9;
  localparam int SLOT_W       = $clog2(CAPACITY + 1);
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int ENTRY_W      = KEY_BITS + PAYLOAD_BITS;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef struct packed {
    logic                    req_type;
    logic [KEY_BITS-1:0]     new_key;
    logic [PAYLOAD_BITS-1:0] new_payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [FILL_W-1:0]       fill_level;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_RM_ROOT,
    S_RM_LAST,
    S_DN_CHK,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DN_CMP,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_PARENT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_CUR,
    WR_RDATA,
    WR_CHILD
  } wr_sel_e;

  typedef struct packed {
    logic    ld_insert;
    logic    ld_full;
    logic    ld_empty;
    logic    ld_remove;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    up_step;
    logic    set_root;
    logic    cap_last;
    logic    cap_left;
    logic    cap_right;
    logic    dn_step;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_is_root;
    logic left_beyond;
    logic has_right;
    logic up_less;
    logic right_less;
    logic down_greater;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/bmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/bmhq_datapath.sv
// Heap datapath: entry storage, sift registers, compares, result registers.
// Depends on bmhq_pkg and bmhq_ram.
`default_nettype none

module bmhq_datapath
  import bmhq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_data_i,
  input  wire cmd_t      cmd_i,
  output stat_t          stat_o,
  output out_item_t      out_data_o
);

  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] pos_q, child_pos_q;
  entry_t            cur_q, child_q, rd_entry, wr_entry;
  out_item_t         res_q, out_q;

  logic [SLOT_W:0]   left_slot, right_slot, cnt_ext, rd_slot, rd_slot_m1;
  logic [SLOT_W-1:0] last_slot, pos_m1;
  logic [ENTRY_W-1:0] ram_rdata;

  assign left_slot  = {pos_q, 1'b0};
  assign right_slot = {pos_q, 1'b1};
  assign cnt_ext    = {1'b0, cnt_q};
  assign last_slot  = cnt_q + SLOT_W'(1);
  assign pos_m1     = pos_q - SLOT_W'(1);
  assign rd_entry   = entry_t'(ram_rdata);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ROOT:   rd_slot = (SLOT_W+1)'(1);
      RD_PARENT: rd_slot = {2'b00, pos_q[SLOT_W-1:1]};
      RD_LAST:   rd_slot = {1'b0, last_slot};
      RD_LEFT:   rd_slot = left_slot;
      RD_RIGHT:  rd_slot = right_slot;
      default:   rd_slot = (SLOT_W+1)'(1);
    endcase
  end
  assign rd_slot_m1 = rd_slot - (SLOT_W+1)'(1);

  always_comb begin
    case (cmd_i.wr_sel)
      WR_CUR:   wr_entry = cur_q;
      WR_RDATA: wr_entry = rd_entry;
      WR_CHILD: wr_entry = child_q;
      default:  wr_entry = cur_q;
    endcase
  end

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (pos_m1[ADDR_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_slot_m1[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.ld_insert) begin
      cnt_d = cnt_q + SLOT_W'(1);
    end else if (cmd_i.ld_remove) begin
      cnt_d = cnt_q - SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_insert) begin
      cur_q <= '{key: in_data_i.new_key, payload: in_data_i.new_payload};
      pos_q <= cnt_d;
      res_q <= '{status: STAT_OK, out_key: '0, out_payload: '0,
                 fill_level: FILL_W'(cnt_d)};
    end
    if (cmd_i.ld_full) begin
      res_q <= '{status: STAT_FULL, out_key: '0, out_payload: '0,
                 fill_level: FILL_W'(CAPACITY)};
    end
    if (cmd_i.ld_empty) begin
      res_q <= '{status: STAT_EMPTY, out_key: '0, out_payload: '0,
                 fill_level: '0};
    end
    if (cmd_i.ld_remove) begin
      res_q.status     <= STAT_OK;
      res_q.fill_level <= FILL_W'(cnt_d);
    end
    if (cmd_i.set_root) begin
      res_q.out_key     <= rd_entry.key;
      res_q.out_payload <= rd_entry.payload;
    end
    if (cmd_i.cap_last) begin
      cur_q <= rd_entry;
      pos_q <= SLOT_W'(1);
    end
    if (cmd_i.up_step) begin
      pos_q <= {1'b0, pos_q[SLOT_W-1:1]};
    end
    if (cmd_i.cap_left) begin
      child_q     <= rd_entry;
      child_pos_q <= left_slot[SLOT_W-1:0];
    end
    if (cmd_i.cap_right) begin
      child_q     <= rd_entry;
      child_pos_q <= right_slot[SLOT_W-1:0];
    end
    if (cmd_i.dn_step) begin
      pos_q <= child_pos_q;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign stat_o.full         = (cnt_q == SLOT_W'(CAPACITY));
  assign stat_o.empty        = (cnt_q == '0);
  assign stat_o.pos_is_root  = (pos_q == SLOT_W'(1));
  assign stat_o.left_beyond  = (left_slot > cnt_ext);
  assign stat_o.has_right    = (left_slot < cnt_ext);
  assign stat_o.up_less      = (cur_q.key < rd_entry.key);
  assign stat_o.right_less   = (rd_entry.key < child_q.key);
  assign stat_o.down_greater = (cur_q.key > child_q.key);

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: sv/bmhq_ctrl.sv
// Heap controller: sequences sift-up / sift-down and the result handshake.
// Depends on bmhq_pkg.
`default_nettype none

module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  req_type_i,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   resp_free;

  assign resp_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_INSERT) begin
            state_d = stat_i.full ? S_RESP : S_UP_CHK;
          end else begin
            state_d = stat_i.empty ? S_RESP : S_RM_ROOT;
          end
        end
      end
      S_UP_CHK:   state_d = stat_i.pos_is_root ? S_RESP : S_UP_CMP;
      S_UP_CMP:   state_d = stat_i.up_less ? S_UP_CHK : S_RESP;
      S_RM_ROOT:  state_d = S_RM_LAST;
      S_RM_LAST:  state_d = S_DN_CHK;
      S_DN_CHK:   state_d = stat_i.left_beyond ? S_RESP : S_DN_LEFT;
      S_DN_LEFT:  state_d = stat_i.has_right ? S_DN_RIGHT : S_DN_CMP;
      S_DN_RIGHT: state_d = S_DN_CMP;
      S_DN_CMP:   state_d = stat_i.down_greater ? S_DN_CHK : S_RESP;
      S_RESP: begin
        if (resp_free) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_ROOT;
    cmd_o.wr_sel = WR_CUR;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == REQ_INSERT) begin
            cmd_o.ld_full   = stat_i.full;
            cmd_o.ld_insert = !stat_i.full;
          end else if (stat_i.empty) begin
            cmd_o.ld_empty = 1'b1;
          end else begin
            cmd_o.ld_remove = 1'b1;
            cmd_o.rd_en     = 1'b1;
            cmd_o.rd_sel    = RD_ROOT;
          end
        end
      end
      S_UP_CHK: begin
        if (stat_i.pos_is_root) begin
          cmd_o.wr_en = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PARENT;
        end
      end
      S_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.up_less) begin
          cmd_o.wr_sel  = WR_RDATA;
          cmd_o.up_step = 1'b1;
        end
      end
      S_RM_ROOT: begin
        cmd_o.set_root = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_LAST;
      end
      S_RM_LAST: cmd_o.cap_last = 1'b1;
      S_DN_CHK: begin
        if (stat_i.left_beyond) begin
          cmd_o.wr_en = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LEFT;
        end
      end
      S_DN_LEFT: begin
        cmd_o.cap_left = 1'b1;
        if (stat_i.has_right) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_RIGHT;
        end
      end
      S_DN_RIGHT: cmd_o.cap_right = stat_i.right_less;
      S_DN_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.down_greater) begin
          cmd_o.wr_sel  = WR_CHILD;
          cmd_o.dn_step = 1'b1;
        end
      end
      S_RESP:  cmd_o.load_out = resp_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/binary_min_heap_queue.sv
// Binary min-heap queue, top level. Depends on bmhq_pkg, bmhq_ctrl, bmhq_datapath.
// Insert sifts the new entry up, at most 8 levels toward the root; remove moves the last
//   entry to the root and sifts it down; an insert when full or a remove when empty goes
//   straight to the result state.
// Throughput: one transaction at a time; the single RAM read port sets the per-level cost,
//   and a finished result waits while the output register is held. Reset: async active low
//   clears the entry count and controller; the entry RAM needs no clearing pass.
`default_nettype none

module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  // command and status between the controller and the datapath
  cmd_t  cmd;
  stat_t stat;

  // controller: request decode, sift sequencing, output handshake
  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // datapath: entry RAM (one-based slots mapped to address slot-1),
  // moving entry, candidate child, count and result registers
  bmhq_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
